// ===== hdl/llf_pkg.sv =====
// Shared constants, types and codes for the least-laxity scheduler.
`default_nettype none
package llf_pkg;

  localparam int MAX_TASK_COUNT = 32;
  localparam int PROC_COUNT     = 4;
  localparam int ID_W           = 5;
  localparam int ID_SPACE       = 1 << ID_W;
  localparam int TIME_W         = 32;
  localparam int KEY_W          = TIME_W + 1;
  localparam int PROC_W         = 2;
  localparam int IDX_W          = (MAX_TASK_COUNT > 1) ? $clog2(MAX_TASK_COUNT) : 1;
  localparam int CNT_W          = $clog2(MAX_TASK_COUNT + 1);
  localparam int PIDX_W         = (PROC_COUNT > 1) ? $clog2(PROC_COUNT) : 1;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_ROUND = 1'b1
  } kind_t;

  // Item as it travels from the front part to the back part.
  // key is deadline minus remaining time, two's complement.
  typedef struct packed {
    kind_t             kind;
    logic [ID_W-1:0]   task_id;
    logic              aper;
    logic [KEY_W-1:0]  key;
  } item_t;

endpackage
`default_nettype wire

// ===== hdl/llf_in_if.sv =====
// Input channel: valid/ready handshake with the task or round payload.
`default_nettype none
interface llf_in_if
  import llf_pkg::*;
;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [ID_W-1:0]             task_id;
  logic                        is_aperiodic;
  logic [TIME_W-1:0]           abs_deadline;
  logic [TIME_W-1:0]           remaining_time;
  logic [TIME_W-1:0]           now;

  modport source (output valid, mode, task_id, is_aperiodic, abs_deadline,
                  remaining_time, now, input ready);
  modport sink   (input valid, mode, task_id, is_aperiodic, abs_deadline,
                  remaining_time, now, output ready);
endinterface
`default_nettype wire

// ===== hdl/llf_out_if.sv =====
// Result channel: valid/ready handshake with one processor line.
`default_nettype none
interface llf_out_if
  import llf_pkg::*;
;
  logic                        valid;
  logic                        ready;
  logic [PROC_W-1:0]           processor_index;
  logic                        busy_res;
  logic [ID_W-1:0]             running_task;
  logic                        running_aperiodic;
  logic                        last;

  modport source (output valid, processor_index, busy_res, running_task,
                  running_aperiodic, last, input ready);
  modport sink   (input valid, processor_index, busy_res, running_task,
                  running_aperiodic, last, output ready);
endinterface
`default_nettype wire

// ===== hdl/llf_front.sv =====
// Front part: accept items, classify them, precompute the sort key, queue them.
`default_nettype none
module llf_front
  import llf_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  llf_in_if.sink     in_ch,
  output logic       q_valid,
  input  wire logic  q_ready,
  output item_t      q_item
);

  item_t       buf_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  fill_r, fill_nxt;
  logic        push, pop;
  item_t       new_item;

  // Classify and build the queued item; laxity order equals key order
  always_comb begin
    new_item.kind    = in_ch.mode ? KIND_ROUND : KIND_LOAD;
    new_item.task_id = in_ch.task_id;
    new_item.aper    = in_ch.is_aperiodic;
    new_item.key     = {1'b0, in_ch.abs_deadline} - {1'b0, in_ch.remaining_time};
  end

  assign in_ch.ready = (fill_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (fill_r != 2'd0);
  assign pop         = q_valid && q_ready;
  assign q_item      = buf_r[rd_ptr_r];

  // Advance queue pointers and fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Hold the payload in the queue slots
  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= new_item;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/llf_back.sv =====
// Back part: task table, affinity memory, selection sequencer, result lines.
`default_nettype none
module llf_back
  import llf_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_valid,
  output logic       q_ready,
  input  wire item_t q_item,
  llf_out_if.source  out_ch
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_PLACE = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    scan_r, scan_nxt;
  logic                pass_r, pass_nxt;
  logic                found_r, found_nxt;
  logic [IDX_W-1:0]    best_r, best_nxt;
  logic [KEY_W-1:0]    bestkey_r, bestkey_nxt;
  logic [PIDX_W-1:0]   emit_r, emit_nxt;

  logic [ID_W-1:0]     tbl_id_r  [MAX_TASK_COUNT];
  logic                tbl_ap_r  [MAX_TASK_COUNT];
  logic [KEY_W-1:0]    tbl_key_r [MAX_TASK_COUNT];
  logic [MAX_TASK_COUNT-1:0] used_r, used_nxt;

  logic [ID_SPACE-1:0] aff_v_r, aff_v_nxt;
  logic [PIDX_W-1:0]   aff_p_r [ID_SPACE];

  logic [PROC_COUNT-1:0] taken_r, taken_nxt;
  logic [ID_W-1:0]     who_r   [PROC_COUNT];
  logic [PROC_COUNT-1:0] apon_r;

  logic                accept;
  logic                tbl_wr;
  logic [IDX_W-1:0]    scan_idx;
  logic                cand;
  logic [ID_W-1:0]     sel_id;
  logic [PIDX_W-1:0]   low_free;
  logic [PIDX_W-1:0]   pick;
  logic                place_en;
  logic [PROC_COUNT-1:0] pick_mask;

  assign q_ready  = (state_r == ST_IDLE);
  assign accept   = q_valid && q_ready;
  assign tbl_wr   = accept && (q_item.kind == KIND_LOAD) &&
                    (cnt_r < CNT_W'(MAX_TASK_COUNT));
  assign scan_idx = scan_r[IDX_W-1:0];
  assign cand     = !used_r[scan_idx] && (tbl_ap_r[scan_idx] == pass_r);
  assign sel_id   = tbl_id_r[best_r];

  // Find the lowest free processor
  always_comb begin
    low_free = '0;
    for (int p = PROC_COUNT - 1; p >= 0; p--) begin
      if (!taken_r[p]) begin
        low_free = PIDX_W'(p);
      end
    end
  end

  // Periodic task keeps its remembered processor when that one is free
  always_comb begin
    pick = low_free;
    if (!pass_r && aff_v_r[sel_id] && !taken_r[aff_p_r[sel_id]]) begin
      pick = aff_p_r[sel_id];
    end
    pick_mask = '0;
    pick_mask[pick] = 1'b1;
  end

  assign place_en = (state_r == ST_PLACE) && found_r;

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    scan_nxt    = scan_r;
    pass_nxt    = pass_r;
    found_nxt   = found_r;
    best_nxt    = best_r;
    bestkey_nxt = bestkey_r;
    emit_nxt    = emit_r;
    used_nxt    = used_r;
    taken_nxt   = taken_r;
    aff_v_nxt   = aff_v_r;
    unique case (state_r)
      ST_IDLE: begin
        if (tbl_wr) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        if (accept && (q_item.kind == KIND_ROUND)) begin
          used_nxt  = '0;
          taken_nxt = '0;
          pass_nxt  = 1'b0;
          scan_nxt  = '0;
          found_nxt = 1'b0;
          emit_nxt  = '0;
          state_nxt = (cnt_r == '0) ? ST_EMIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cand && (!found_r || ($signed(tbl_key_r[scan_idx]) < $signed(bestkey_r)))) begin
          found_nxt   = 1'b1;
          best_nxt    = scan_idx;
          bestkey_nxt = tbl_key_r[scan_idx];
        end
        scan_nxt = scan_r + CNT_W'(1);
        if (scan_r == cnt_r - CNT_W'(1)) begin
          state_nxt = ST_PLACE;
        end
      end
      ST_PLACE: begin
        scan_nxt  = '0;
        found_nxt = 1'b0;
        if (!found_r) begin
          if (!pass_r) begin
            pass_nxt  = 1'b1;
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_EMIT;
          end
        end else begin
          used_nxt[best_r] = 1'b1;
          taken_nxt        = taken_r | pick_mask;
          if (!pass_r) begin
            aff_v_nxt[sel_id] = 1'b1;
          end
          state_nxt = (&(taken_r | pick_mask)) ? ST_EMIT : ST_SCAN;
        end
      end
      ST_EMIT: begin
        if (out_ch.ready) begin
          if (emit_r == PIDX_W'(PROC_COUNT - 1)) begin
            cnt_nxt   = '0;
            emit_nxt  = '0;
            state_nxt = ST_IDLE;
          end else begin
            emit_nxt = emit_r + PIDX_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      scan_r  <= '0;
      pass_r  <= 1'b0;
      found_r <= 1'b0;
      emit_r  <= '0;
      used_r  <= '0;
      taken_r <= '0;
      aff_v_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      scan_r  <= scan_nxt;
      pass_r  <= pass_nxt;
      found_r <= found_nxt;
      emit_r  <= emit_nxt;
      used_r  <= used_nxt;
      taken_r <= taken_nxt;
      aff_v_r <= aff_v_nxt;
    end
  end

  // Payload storage: table, best candidate, placements, affinity
  always_ff @(posedge clk) begin
    best_r    <= best_nxt;
    bestkey_r <= bestkey_nxt;
    if (tbl_wr) begin
      tbl_id_r[cnt_r[IDX_W-1:0]]  <= q_item.task_id;
      tbl_ap_r[cnt_r[IDX_W-1:0]]  <= q_item.aper;
      tbl_key_r[cnt_r[IDX_W-1:0]] <= q_item.key;
    end
    if (place_en) begin
      who_r[pick]  <= sel_id;
      apon_r[pick] <= pass_r;
      if (!pass_r) begin
        aff_p_r[sel_id] <= pick;
      end
    end
  end

  // Drive the result line for the current processor
  always_comb begin
    out_ch.valid             = (state_r == ST_EMIT);
    out_ch.processor_index   = PROC_W'(emit_r);
    out_ch.busy_res          = taken_r[emit_r];
    out_ch.running_task      = taken_r[emit_r] ? who_r[emit_r] : '0;
    out_ch.running_aperiodic = taken_r[emit_r] && apon_r[emit_r];
    out_ch.last              = (emit_r == PIDX_W'(PROC_COUNT - 1));
  end

endmodule
`default_nettype wire

// ===== hdl/least_laxity_multiprocessor_scheduler_top.sv =====
// Top level of the least-laxity multiprocessor scheduler.
//
//   Channel  Dir  Handshake     Moves
//   in_ch    in   valid/ready   one load or one scheduling round
//   out_ch   out  valid/ready   one processor line (PROC_COUNT per round)
//
// The back part takes a load only while idle; a two-entry queue lets loads
// arrive every cycle while the back part is idle. A round scans the task
// table (one entry per cycle through the comparator), then sends one
// result line per processor.
// Reset (synchronous, rst_n low) empties the table and clears all affinity.
// A stalled result line holds; the queue keeps accepting until it is full.
`default_nettype none
module least_laxity_multiprocessor_scheduler_top
  import llf_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  llf_in_if.sink     in_ch,
  llf_out_if.source  out_ch
);

  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  llf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item)
  );

  llf_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

// ===== hdl/llf_checker.sv =====
// Port-level checks on the result channel, bound to the top level.
`default_nettype none
module llf_checker
  import llf_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [PROC_W-1:0] out_index,
  input wire logic             out_busy,
  input wire logic [ID_W-1:0]  out_task,
  input wire logic             out_aper,
  input wire logic             out_last
);

  // Last line is exactly the final processor
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_index == PROC_W'(PROC_COUNT - 1))))
    else $error("last flag does not match processor index");

  // Idle lines carry no task
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_busy) |-> (out_task == '0 && !out_aper))
    else $error("idle line carries a task");

  // Lines of a round follow one another without a gap
  a_next_line: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=>
      (out_valid && out_index == $past(out_index) + PROC_W'(1)))
    else $error("round lines out of sequence");

  // A stalled line holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_index) && $stable(out_task) && $stable(out_busy)))
    else $error("stalled line changed");

endmodule

bind least_laxity_multiprocessor_scheduler_top llf_checker u_llf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_index (out_ch.processor_index),
  .out_busy  (out_ch.busy_res),
  .out_task  (out_ch.running_task),
  .out_aper  (out_ch.running_aperiodic),
  .out_last  (out_ch.last)
);
`default_nettype wire
